// File: rtl/assert_macros.svh
// Assertion macros, included by the executor top level.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, masked by reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication, masked by reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// File: rtl/sme_pkg.sv
// Package for the stack machine executor: types, codes and constants.
// No dependencies.
package sme_pkg;
   localparam int MemDepth = 1024;
   localparam int AddrBits = $clog2(MemDepth);

   localparam logic [7:0] OP_POP   = 8'd0;
   localparam logic [7:0] OP_IPOP  = 8'd1;
   localparam logic [7:0] OP_PUSH  = 8'd2;
   localparam logic [7:0] OP_IPUSH = 8'd3;
   localparam logic [7:0] OP_PUSHI = 8'd4;
   localparam logic [7:0] OP_JMP   = 8'd5;
   localparam logic [7:0] OP_JNZ   = 8'd6;
   localparam logic [7:0] OP_CALL  = 8'd7;
   localparam logic [7:0] OP_RET   = 8'd8;
   localparam logic [7:0] OP_READ  = 8'd9;
   localparam logic [7:0] OP_WRITE = 8'd10;
   localparam logic [7:0] OP_ALU   = 8'd11;
   localparam logic [7:0] OP_RND   = 8'd12;
   localparam logic [7:0] OP_DUP   = 8'd13;
   localparam logic [7:0] OP_HALT  = 8'd99;

   localparam logic [3:0] ALU_EQ  = 4'd0;
   localparam logic [3:0] ALU_NE  = 4'd1;
   localparam logic [3:0] ALU_GE  = 4'd2;
   localparam logic [3:0] ALU_LE  = 4'd3;
   localparam logic [3:0] ALU_GT  = 4'd4;
   localparam logic [3:0] ALU_LT  = 4'd5;
   localparam logic [3:0] ALU_OR  = 4'd6;
   localparam logic [3:0] ALU_XOR = 4'd7;
   localparam logic [3:0] ALU_AND = 4'd8;
   localparam logic [3:0] ALU_NOT = 4'd9;
   localparam logic [3:0] ALU_ADD = 4'd10;
   localparam logic [3:0] ALU_SUB = 4'd11;
   localparam logic [3:0] ALU_MUL = 4'd12;
   localparam logic [3:0] ALU_DIV = 4'd13;
   localparam logic [3:0] ALU_MOD = 4'd14;
   localparam logic [3:0] ALU_NEG = 4'd15;

   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_HALT    = 3'd1;
   localparam logic [2:0] ST_ACCESS  = 3'd2;
   localparam logic [2:0] ST_OPCODE  = 3'd3;
   localparam logic [2:0] ST_BADOP   = 3'd4;
   localparam logic [2:0] ST_PCOUT   = 3'd5;
   localparam logic [2:0] ST_IGNORED = 3'd6;
   localparam logic [2:0] ST_DIVZERO = 3'd7;

   localparam logic CSR_MEM_WORDS = 1'b0;
   localparam logic CSR_PROG_LEN  = 1'b1;

   typedef struct packed {
      logic [7:0]         opcode;
      logic signed [15:0] operand;
      logic signed [15:0] input_value;
      logic [14:0]        random_value;
   } req_type;

   typedef struct packed {
      logic signed [15:0] next_pc;
      logic               write_valid;
      logic signed [15:0] write_value;
      logic [2:0]         status;
      logic signed [11:0] stack_level;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_POP, S_POPWAIT, S_RDMEM, S_RDWAIT,
      S_EXEC, S_DIVWAIT, S_PUSH, S_STORE, S_FINISH, S_RESP
   } state_type;

   typedef struct packed {
      logic        start;
      logic        is_mod;
      logic [15:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] result;
   } div_rsp_type;
endpackage

// File: rtl/sme_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sme_ram #(
   parameter int Width = 16,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end
   assign rd_data = rd_ff;
endmodule

// File: rtl/sme_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on sme_pkg.
module sme_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  sme_pkg::div_req_type div_req,
   output sme_pkg::div_rsp_type div_rsp
);
   logic        busy_ff, busy_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] quot_ff, quot_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in, mod_ff, mod_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [15:0] q_res, r_res;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      mod_in   = mod_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[15:0], quot_ff[15]} - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = 5'd16;
         quot_in  = div_req.num[15] ? 16'(-div_req.num) : div_req.num;
         den_in   = div_req.den[15] ? 16'(-div_req.den) : div_req.den;
         rem_in   = '0;
         qneg_in  = div_req.num[15] ^ div_req.den[15];
         rneg_in  = div_req.num[15];
         mod_in   = div_req.is_mod;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial;
         end else begin
            rem_in = {rem_ff[15:0], quot_ff[15]};
         end
         quot_in  = {quot_ff[14:0], !trial[16]};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      mod_ff  <= mod_in;
   end

   assign q_res = qneg_ff ? 16'(-quot_ff) : quot_ff;
   assign r_res = rneg_ff ? 16'(-rem_ff[15:0]) : rem_ff[15:0];
   assign div_rsp.done   = done_ff;
   assign div_rsp.result = mod_ff ? r_res : q_res;
endmodule

// File: rtl/stack_machine_executor_unit.sv
// Top level of the stack machine executor: sequencer, memory and divider.
// Depends on sme_pkg, sme_ram, sme_divider and assert_macros.svh.
`include "assert_macros.svh"
//
//  channel | direction | handshake       | payload
//  --------+-----------+-----------------+--------------------------
//  req     | in        | req_valid/ready | sme_pkg::req_type
//  rsp     | out       | rsp_valid/ready | sme_pkg::rsp_type
//  csr     | in        | csr_write       | index 1 bit, data 15 bit
//
// One instruction at a time. Each read through the single RAM port takes an address
// state and then a registered-data state; a write needs only the address state.
// ALU div/mod pops two operands and then waits on the 16-step divider.
// A finished result is staged in fin_ff and moves to the rsp register once that
// is free; while rsp holds an untaken transfer the sequencer waits in S_RESP and
// req_ready stays low. Synchronous reset clears control state only; the data
// memory is not cleared.
module stack_machine_executor_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sme_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sme_pkg::rsp_type rsp_payload,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [14:0]      csr_data
);
   localparam int AW = sme_pkg::AddrBits;

   sme_pkg::state_type state_ff, state_in;
   logic [10:0]        memw_ff, memw_in;
   logic [14:0]        plen_ff, plen_in;
   logic [15:0]        pc_ff, pc_in;
   logic signed [11:0] sp_ff, sp_in;
   logic               stop_ff, stop_in;
   sme_pkg::req_type   item_ff, item_in;
   logic [2:0]         step_ff, step_in;      // micro-step within instruction
   logic [15:0]        a_ff, a_in, b_ff, b_in;
   logic [15:0]        res_ff, res_in;
   sme_pkg::rsp_type   fin_ff, fin_in;        // finished result, not yet in rsp
   sme_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rspv_ff, rspv_in;

   logic [2:0]  status;        // status to finish with
   logic        finish_now;
   logic [15:0] npc;
   logic        wv;
   logic [15:0] wval;

   // memory port
   logic           ram_we;
   logic [AW-1:0]  ram_addr;
   logic [15:0]    ram_wdata, ram_rdata;
   // access request from the sequencer
   logic signed [16:0] acc_addr;
   logic               acc_ok;
   logic [10:0]        mem_size;

   sme_pkg::div_req_type div_req;
   sme_pkg::div_rsp_type div_rsp;

   logic [3:0]  aop;
   logic        two_pop;
   logic        pops_left;
   logic [15:0] alu_r;
   logic signed [15:0] sa, sb;
   logic [31:0] prod;

   sme_ram #(.Width(16), .Depth(sme_pkg::MemDepth)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   sme_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign mem_size = (memw_ff > 11'(sme_pkg::MemDepth)) ? 11'(sme_pkg::MemDepth) : memw_ff;
   assign acc_ok   = !acc_addr[16] && (acc_addr < 17'(mem_size));
   assign aop      = item_ff.operand[3:0];
   assign two_pop  = !(aop == sme_pkg::ALU_NOT || aop == sme_pkg::ALU_NEG);
   assign sa = a_ff;
   assign sb = b_ff;
   assign prod = 32'(sa * sb);

   // ALU, single shared unit
   always_comb begin
      alu_r = '0;
      case (aop)
         sme_pkg::ALU_EQ:  alu_r = {15'd0, sa == sb};
         sme_pkg::ALU_NE:  alu_r = {15'd0, sa != sb};
         sme_pkg::ALU_GE:  alu_r = {15'd0, sa >= sb};
         sme_pkg::ALU_LE:  alu_r = {15'd0, sa <= sb};
         sme_pkg::ALU_GT:  alu_r = {15'd0, sa > sb};
         sme_pkg::ALU_LT:  alu_r = {15'd0, sa < sb};
         sme_pkg::ALU_OR:  alu_r = a_ff | b_ff;
         sme_pkg::ALU_XOR: alu_r = a_ff ^ b_ff;
         sme_pkg::ALU_AND: alu_r = a_ff & b_ff;
         sme_pkg::ALU_NOT: alu_r = ~a_ff;
         sme_pkg::ALU_ADD: alu_r = a_ff + b_ff;
         sme_pkg::ALU_SUB: alu_r = a_ff - b_ff;
         sme_pkg::ALU_MUL: alu_r = prod[15:0];
         sme_pkg::ALU_NEG: alu_r = 16'(-a_ff);
         default:          alu_r = div_rsp.result;
      endcase
   end

   // Sequencer. ALU pops land in b then a, other pops in a then b; step_ff counts
   // remaining pops / pushes. The order of memory events follows the instruction set.
   // Taken jumps land one past the target (pc + offset, then the usual +1).
   always_comb begin
      state_in = state_ff;
      memw_in  = memw_ff;
      plen_in  = plen_ff;
      pc_in    = pc_ff;
      sp_in    = sp_ff;
      stop_in  = stop_ff;
      item_in  = item_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      fin_in   = fin_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff;
      status   = sme_pkg::ST_RUN;
      finish_now = 1'b0;
      npc      = pc_ff + 16'd1;
      wv       = 1'b0;
      wval     = '0;
      ram_we   = 1'b0;
      acc_addr = 17'(sp_ff);
      ram_wdata = res_ff;
      div_req  = '0;
      pops_left = 1'b0;

      if (csr_write) begin
         if (csr_index == sme_pkg::CSR_MEM_WORDS) begin
            memw_in = csr_data[10:0];
         end else begin
            plen_in = csr_data;
         end
      end
      if (rspv_ff && rsp_ready) begin
         rspv_in = 1'b0;
      end

      unique case (state_ff)
         sme_pkg::S_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               state_in = sme_pkg::S_DISPATCH;
            end
         end
         sme_pkg::S_DISPATCH: begin
            if (stop_ff) begin
               status = sme_pkg::ST_IGNORED;
               finish_now = 1'b1;
            end else if (pc_ff[15] || pc_ff[14:0] >= plen_ff) begin
               status = sme_pkg::ST_PCOUT;
               finish_now = 1'b1;
            end else begin
               case (item_ff.opcode)
                  sme_pkg::OP_POP, sme_pkg::OP_IPUSH, sme_pkg::OP_JNZ,
                  sme_pkg::OP_RET, sme_pkg::OP_DUP: begin
                     step_in = 3'd1;
                     state_in = sme_pkg::S_POP;
                  end
                  sme_pkg::OP_IPOP: begin
                     step_in = 3'd2;
                     state_in = sme_pkg::S_POP;
                  end
                  sme_pkg::OP_ALU: begin
                     if (item_ff.operand[15:4] != 12'd0) begin
                        // bad op still pops two
                        step_in = 3'd2;
                     end else begin
                        step_in = two_pop ? 3'd2 : 3'd1;
                     end
                     state_in = sme_pkg::S_POP;
                  end
                  sme_pkg::OP_PUSH, sme_pkg::OP_WRITE: begin
                     state_in = sme_pkg::S_RDMEM;
                  end
                  sme_pkg::OP_PUSHI: begin
                     res_in = item_ff.operand;
                     step_in = 3'd1;
                     state_in = sme_pkg::S_PUSH;
                  end
                  sme_pkg::OP_JMP: begin
                     npc = pc_ff + item_ff.operand + 16'd1;
                     finish_now = 1'b1;
                  end
                  sme_pkg::OP_CALL: begin
                     res_in = pc_ff;
                     step_in = 3'd1;
                     state_in = sme_pkg::S_PUSH;
                  end
                  sme_pkg::OP_READ: begin
                     res_in = item_ff.input_value;
                     state_in = sme_pkg::S_STORE;
                  end
                  sme_pkg::OP_RND: begin
                     if (item_ff.operand == 16'sd0) begin
                        status = sme_pkg::ST_DIVZERO;
                        finish_now = 1'b1;
                     end else begin
                        div_req.start  = 1'b1;
                        div_req.is_mod = 1'b1;
                        div_req.num    = {1'b0, item_ff.random_value};
                        div_req.den    = item_ff.operand;
                        state_in = sme_pkg::S_DIVWAIT;
                     end
                  end
                  sme_pkg::OP_HALT: begin
                     status = sme_pkg::ST_HALT;
                     finish_now = 1'b1;
                  end
                  default: begin
                     status = sme_pkg::ST_OPCODE;
                     finish_now = 1'b1;
                  end
               endcase
            end
         end
         sme_pkg::S_POP: begin
            sp_in = sp_ff - 12'sd1;
            acc_addr = 17'(sp_ff - 12'sd1);
            if (!acc_ok) begin
               status = sme_pkg::ST_ACCESS;
               finish_now = 1'b1;
            end else begin
               state_in = sme_pkg::S_POPWAIT;
            end
         end
         sme_pkg::S_POPWAIT: begin
            // data for the address registered last cycle
            pops_left = (step_ff != 3'd1);
            step_in = step_ff - 3'd1;
            if (item_ff.opcode == sme_pkg::OP_ALU && pops_left) begin
               b_in = ram_rdata;
            end else if (item_ff.opcode == sme_pkg::OP_ALU) begin
               a_in = ram_rdata;
            end else if (item_ff.opcode == sme_pkg::OP_IPOP && !pops_left) begin
               b_in = ram_rdata;
            end else begin
               a_in = ram_rdata;
            end
            if (pops_left) begin
               state_in = sme_pkg::S_POP;
            end else begin
               state_in = sme_pkg::S_EXEC;
            end
         end
         sme_pkg::S_RDMEM: begin
            if (item_ff.opcode == sme_pkg::OP_IPUSH) begin
               acc_addr = 17'(signed'(a_ff));
            end else begin
               acc_addr = 17'(item_ff.operand);
            end
            if (!acc_ok) begin
               status = sme_pkg::ST_ACCESS;
               finish_now = 1'b1;
            end else begin
               state_in = sme_pkg::S_RDWAIT;
            end
         end
         sme_pkg::S_RDWAIT: begin
            res_in = ram_rdata;
            if (item_ff.opcode == sme_pkg::OP_WRITE) begin
               wv = 1'b1;
               wval = ram_rdata;
               finish_now = 1'b1;
            end else begin
               step_in = 3'd1;
               state_in = sme_pkg::S_PUSH;
            end
         end
         sme_pkg::S_EXEC: begin
            case (item_ff.opcode)
               sme_pkg::OP_POP: begin
                  res_in = a_ff;
                  state_in = sme_pkg::S_STORE;
               end
               sme_pkg::OP_IPOP: begin
                  res_in = b_ff;
                  state_in = sme_pkg::S_STORE;
               end
               sme_pkg::OP_IPUSH: begin
                  state_in = sme_pkg::S_RDMEM;
               end
               sme_pkg::OP_JNZ: begin
                  if (a_ff != 16'd0) begin
                     npc = pc_ff + item_ff.operand + 16'd1;
                  end
                  finish_now = 1'b1;
               end
               sme_pkg::OP_RET: begin
                  npc = a_ff + 16'd1;
                  finish_now = 1'b1;
               end
               sme_pkg::OP_DUP: begin
                  res_in = a_ff;
                  step_in = 3'd2;
                  state_in = sme_pkg::S_PUSH;
               end
               default: begin
                  // ALU
                  if (item_ff.operand[15:4] != 12'd0) begin
                     status = sme_pkg::ST_BADOP;
                     finish_now = 1'b1;
                  end else if ((aop == sme_pkg::ALU_DIV || aop == sme_pkg::ALU_MOD)) begin
                     if (b_ff == 16'd0) begin
                        status = sme_pkg::ST_DIVZERO;
                        finish_now = 1'b1;
                     end else begin
                        div_req.start  = 1'b1;
                        div_req.is_mod = (aop == sme_pkg::ALU_MOD);
                        div_req.num    = a_ff;
                        div_req.den    = b_ff;
                        state_in = sme_pkg::S_DIVWAIT;
                     end
                  end else begin
                     res_in = alu_r;
                     step_in = 3'd1;
                     state_in = sme_pkg::S_PUSH;
                  end
               end
            endcase
         end
         sme_pkg::S_DIVWAIT: begin
            if (div_rsp.done) begin
               res_in = div_rsp.result;
               step_in = 3'd1;
               state_in = sme_pkg::S_PUSH;
            end
         end
         sme_pkg::S_PUSH: begin
            sp_in = sp_ff + 12'sd1;
            acc_addr = 17'(sp_ff);
            if (!acc_ok) begin
               status = sme_pkg::ST_ACCESS;
               finish_now = 1'b1;
            end else begin
               ram_we = 1'b1;
               step_in = step_ff - 3'd1;
               if (step_ff == 3'd1) begin
                  if (item_ff.opcode == sme_pkg::OP_CALL) begin
                     npc = pc_ff + item_ff.operand + 16'd1;
                  end
                  finish_now = 1'b1;
               end
            end
         end
         sme_pkg::S_STORE: begin
            if (item_ff.opcode == sme_pkg::OP_IPOP) begin
               acc_addr = 17'(signed'(a_ff));
            end else begin
               acc_addr = 17'(item_ff.operand);
            end
            if (!acc_ok) begin
               status = sme_pkg::ST_ACCESS;
            end else begin
               ram_we = 1'b1;
            end
            finish_now = 1'b1;
         end
         sme_pkg::S_FINISH: begin
            state_in = sme_pkg::S_RESP;
         end
         sme_pkg::S_RESP: begin
            // move the staged result out once the rsp register is free
            if (!rspv_ff || rsp_ready) begin
               rsp_in   = fin_ff;
               state_in = sme_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sme_pkg::S_IDLE;
         end
      endcase

      if (finish_now) begin
         if (status == sme_pkg::ST_RUN) begin
            pc_in = npc;
         end else if (status != sme_pkg::ST_IGNORED) begin
            stop_in = 1'b1;
            wv = 1'b0;
            wval = '0;
         end
         fin_in.next_pc     = (status == sme_pkg::ST_RUN) ? npc : pc_ff;
         fin_in.write_valid = wv;
         fin_in.write_value = wval;
         fin_in.status      = status;
         fin_in.stack_level = sp_in;
         state_in = sme_pkg::S_RESP;
      end
      if (state_ff == sme_pkg::S_RESP && (!rspv_ff || rsp_ready)) begin
         rspv_in = 1'b1;
      end
   end

   assign ram_addr = acc_addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::S_IDLE;
         memw_ff  <= 11'd1024;
         plen_ff  <= '0;
         pc_ff    <= '0;
         sp_ff    <= '0;
         stop_ff  <= 1'b0;
         rspv_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         memw_ff  <= memw_in;
         plen_ff  <= plen_in;
         pc_ff    <= pc_in;
         sp_ff    <= sp_in;
         stop_ff  <= stop_in;
         rspv_ff  <= rspv_in;
         step_ff  <= step_in;
      end
      item_ff <= item_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      res_ff  <= res_in;
      fin_ff  <= fin_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready   = (state_ff == sme_pkg::S_IDLE);
   assign rsp_valid   = rspv_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == sme_pkg::S_IDLE)
   `ASSERT_NEXT(a_stop_sticks, clock, reset, stop_ff, stop_ff)
   `ASSERT_IMPL(a_we_in_range, clock, reset, ram_we, acc_ok)
endmodule

// File: dv/tb_stack_machine_executor_unit.sv
// Self-checking testbench for stack_machine_executor_unit: directed table, then random
// instruction streams checked against an in-bench model of the machine. Depends on sme_pkg.
`timescale 1ns / 1ps
module tb_stack_machine_executor_unit;
   import sme_pkg::*;

   localparam int STALL_LIMIT = 3000;   // cycles without any transfer
   localparam int DRAIN_WAIT  = 40;     // worst instruction is div/mod

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_write;
   logic    csr_index;
   logic [14:0] csr_data;

   stack_machine_executor_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // ---------------------------------------------------------------------
   // Machine model state: memory image, which words hold a known value,
   // stack pointer, pc, the stop flag and the two config registers.
   // ---------------------------------------------------------------------
   logic [15:0] mem_img [MemDepth];
   bit          mem_known [MemDepth];
   int          stack_ptr;
   logic [15:0] cur_pc;
   bit          stopped;
   int          mem_words;
   int          prog_len;

   rsp_type pending_results [$];
   int      fails;
   int      instr_xfers;
   int      result_xfers;
   int      write_outs;
   int      stall_cycles;
   int      burst_left;
   bit      long_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int mem_size();
      return (mem_words < MemDepth) ? mem_words : MemDepth;
   endfunction

   function automatic bit load_word(int a, output int v);
      v = 0;
      if (a < 0 || a >= mem_size()) return 0;
      v = int'($signed(mem_img[a]));
      return 1;
   endfunction

   function automatic bit store_word(int a, int v);
      if (a < 0 || a >= mem_size()) return 0;
      mem_img[a] = v[15:0];
      mem_known[a] = 1'b1;
      return 1;
   endfunction

   // every pop moves the pointer first, every push too, even when the access fails
   function automatic bit pop_word(output int v);
      stack_ptr--;
      return load_word(stack_ptr, v);
   endfunction

   function automatic bit push_word(int v);
      stack_ptr++;
      return store_word(stack_ptr - 1, v);
   endfunction

   function automatic logic [2:0] alu_exec(int p);
      int a, b, r;
      a = 0;
      b = 0;
      r = 0;
      if (p == ALU_NOT || p == ALU_NEG) begin
         if (!pop_word(a)) return ST_ACCESS;
      end else begin
         if (!pop_word(b) || !pop_word(a)) return ST_ACCESS;
      end
      if (p < 0 || p > 15) return ST_BADOP;   // operands stay popped
      case (p[3:0])
         ALU_EQ:  r = (a == b);
         ALU_NE:  r = (a != b);
         ALU_GE:  r = (a >= b);
         ALU_LE:  r = (a <= b);
         ALU_GT:  r = (a > b);
         ALU_LT:  r = (a < b);
         ALU_OR:  r = a | b;
         ALU_XOR: r = a ^ b;
         ALU_AND: r = a & b;
         ALU_NOT: r = ~a;
         ALU_ADD: r = a + b;
         ALU_SUB: r = a - b;
         ALU_MUL: r = a * b;
         ALU_DIV: begin
            if (b == 0) return ST_DIVZERO;
            r = a / b;   // -32768 / -1 wraps back to -32768
         end
         ALU_MOD: begin
            if (b == 0) return ST_DIVZERO;
            r = a % b;
         end
         default: r = -a;
      endcase
      return push_word(r) ? ST_RUN : ST_ACCESS;
   endfunction

   function automatic logic [2:0] run_instr(req_type q, output bit wv, output int wval);
      int p, a, b;
      wv = 1'b0;
      wval = 0;
      p = int'(q.operand);
      case (q.opcode)
         OP_POP:   return (!pop_word(a) || !store_word(p, a)) ? ST_ACCESS : ST_RUN;
         OP_IPOP:  return (!pop_word(a) || !pop_word(b) || !store_word(a, b))
                          ? ST_ACCESS : ST_RUN;
         OP_PUSH:  return (!load_word(p, a) || !push_word(a)) ? ST_ACCESS : ST_RUN;
         OP_IPUSH: return (!pop_word(a) || !load_word(a, b) || !push_word(b))
                          ? ST_ACCESS : ST_RUN;
         OP_PUSHI: return push_word(p) ? ST_RUN : ST_ACCESS;
         OP_JMP: begin
            cur_pc = cur_pc + p[15:0];
            return ST_RUN;
         end
         OP_JNZ: begin
            if (!pop_word(a)) return ST_ACCESS;
            if (a != 0) cur_pc = cur_pc + p[15:0];
            return ST_RUN;
         end
         OP_CALL: begin
            if (!push_word(int'($signed(cur_pc)))) return ST_ACCESS;
            cur_pc = cur_pc + p[15:0];
            return ST_RUN;
         end
         OP_RET: begin
            if (!pop_word(a)) return ST_ACCESS;
            cur_pc = a[15:0];
            return ST_RUN;
         end
         OP_READ:  return store_word(p, int'(q.input_value)) ? ST_RUN : ST_ACCESS;
         OP_WRITE: begin
            if (!load_word(p, a)) return ST_ACCESS;
            wv = 1'b1;
            wval = a;
            return ST_RUN;
         end
         OP_ALU:   return alu_exec(p);
         OP_RND: begin
            if (p == 0) return ST_DIVZERO;
            return push_word(int'(q.random_value) % p) ? ST_RUN : ST_ACCESS;
         end
         OP_DUP:   return (!pop_word(a) || !push_word(a) || !push_word(a))
                          ? ST_ACCESS : ST_RUN;
         OP_HALT:  return ST_HALT;
         default:  return ST_OPCODE;
      endcase
   endfunction

   // One instruction through the model; returns the result it must produce.
   function automatic rsp_type execute_instr(req_type q);
      rsp_type     o;
      logic [2:0]  st;
      logic [15:0] here;
      bit          wv;
      int          wval;
      here = cur_pc;
      wv = 1'b0;
      wval = 0;
      if (stopped)
         st = ST_IGNORED;
      else if (cur_pc[15] || int'(cur_pc) >= prog_len)
         st = ST_PCOUT;
      else
         st = run_instr(q, wv, wval);
      if (st == ST_RUN) begin
         cur_pc = cur_pc + 16'd1;
      end else if (st != ST_IGNORED) begin
         cur_pc = here;
         stopped = 1'b1;
         wv = 1'b0;
         wval = 0;
      end
      o.next_pc = cur_pc;
      o.write_valid = wv;
      o.write_value = wval[15:0];
      o.status = st;
      o.stack_level = stack_ptr[11:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers: only legal, fully defined instructions come out of
   // next_instr, so the machine keeps running deep into the stream.
   // ---------------------------------------------------------------------
   function automatic int pick_target();
      int t;
      if ($urandom_range(0, 3) == 0) begin
         t = int'($urandom_range(0, prog_len - 2));
      end else begin
         t = int'(cur_pc) + int'($urandom_range(0, 40)) - 20;
         if (t < 0) t = 0;
         if (t > prog_len - 2) t = prog_len - 2;
      end
      return t;
   endfunction

   function automatic bit pick_known(output int a);
      int m;
      m = mem_size();
      for (int n = 0; n < 16; n++) begin
         a = int'($urandom_range(0, m - 1));
         if (mem_known[a]) return 1;
      end
      for (a = 0; a < m; a++)
         if (mem_known[a]) return 1;
      return 0;
   endfunction

   function automatic req_type next_instr();
      req_type r;
      int      m, top, a, k;
      bit      top_ok;
      m = mem_size();
      r.operand = 16'($urandom);
      r.input_value = 16'($urandom);
      r.random_value = 15'($urandom);
      top_ok = (stack_ptr >= 1 && stack_ptr <= m);
      top = top_ok ? int'($signed(mem_img[stack_ptr - 1])) : 0;
      // keep the pc away from the end of the program
      if (int'(cur_pc) >= prog_len - 3) begin
         r.opcode = OP_JMP;
         r.operand = 16'(pick_target() - int'(cur_pc));
         return r;
      end
      for (int n = 0; n < 100; n++) begin
         k = (stack_ptr > 10 && $urandom_range(0, 1)) ? int'(OP_POP)
                                                      : int'($urandom_range(0, 13));
         r.opcode = k[7:0];
         case (r.opcode)
            OP_POP: if (top_ok) begin
               r.operand = 16'($urandom_range(0, m - 1));
               return r;
            end
            OP_IPOP: begin
               if (stack_ptr >= 2 && top_ok && top >= 0 && top < m) return r;
               if (stack_ptr < m) begin   // set up an address for a later ipop
                  r.opcode = OP_PUSHI;
                  r.operand = 16'($urandom_range(0, m - 1));
                  return r;
               end
            end
            OP_PUSH: if (stack_ptr < m && pick_known(a)) begin
               r.operand = 16'(a);
               return r;
            end
            OP_IPUSH: begin
               if (top_ok && top >= 0 && top < m && mem_known[top]) return r;
               if (stack_ptr < m && pick_known(a)) begin
                  r.opcode = OP_PUSHI;
                  r.operand = 16'(a);
                  return r;
               end
            end
            OP_PUSHI: if (stack_ptr < m) return r;
            OP_JMP: begin
               r.operand = 16'(pick_target() - int'(cur_pc));
               return r;
            end
            OP_JNZ: if (top_ok) begin
               r.operand = 16'(pick_target() - int'(cur_pc));
               return r;
            end
            OP_CALL: if (stack_ptr < m) begin
               r.operand = 16'(pick_target() - int'(cur_pc));
               return r;
            end
            OP_RET: begin
               if (top_ok && top >= 0 && top <= prog_len - 2) return r;
               if (stack_ptr < m) begin   // return address for a later ret
                  r.opcode = OP_PUSHI;
                  r.operand = 16'(pick_target());
                  return r;
               end
            end
            OP_READ: begin
               r.operand = 16'($urandom_range(0, m - 1));
               return r;
            end
            OP_WRITE: if (pick_known(a)) begin
               r.operand = 16'(a);
               return r;
            end
            OP_ALU: begin
               r.operand = 16'($urandom_range(0, 15));
               if ((r.operand == ALU_DIV || r.operand == ALU_MOD) && top == 0)
                  r.operand = 16'(ALU_SUB);
               if (r.operand == ALU_NOT || r.operand == ALU_NEG) begin
                  if (top_ok) return r;
               end else if (stack_ptr >= 2 && top_ok) begin
                  return r;
               end
            end
            OP_RND: if (stack_ptr < m) begin
               if (r.operand == 16'sd0) r.operand = 16'sd1;
               return r;
            end
            default: if (top_ok && stack_ptr < m) return r;   // dup
         endcase
      end
      r.opcode = OP_JMP;
      r.operand = 16'(pick_target() - int'(cur_pc));
      return r;
   endfunction

   // Directed table: row, instruction, and where obvious, the result typed in.
   function automatic bit directed_row(int i, output req_type r, output rsp_type want);
      bit typed;
      typed = 1'b0;
      want = '0;
      r = '0;
      case (i)
         0:  begin r = '{OP_PUSHI, 16'sd32767, 16'sd0, 15'd0};
                   want = '{16'sd1, 1'b0, 16'sd0, ST_RUN, 12'sd1}; typed = 1'b1; end
         1:  begin r = '{OP_PUSHI, -16'sd32768, 16'sd0, 15'd0};
                   want = '{16'sd2, 1'b0, 16'sd0, ST_RUN, 12'sd2}; typed = 1'b1; end
         2:  begin r = '{OP_ALU, 16'(ALU_ADD), 16'sd0, 15'd0};
                   want = '{16'sd3, 1'b0, 16'sd0, ST_RUN, 12'sd1}; typed = 1'b1; end
         3:  begin r = '{OP_POP, 16'sd1023, 16'sd0, 15'd0};
                   want = '{16'sd4, 1'b0, 16'sd0, ST_RUN, 12'sd0}; typed = 1'b1; end
         4:  begin r = '{OP_WRITE, 16'sd1023, 16'sd0, 15'd0};
                   want = '{16'sd5, 1'b1, -16'sd1, ST_RUN, 12'sd0}; typed = 1'b1; end
         5:  r = '{OP_READ, 16'sd0, -16'sd32768, 15'd0};
         6:  r = '{OP_READ, 16'sd1, 16'sd32767, 15'd0};
         7:  r = '{OP_PUSH, 16'sd0, 16'sd0, 15'd0};
         8:  r = '{OP_PUSHI, -16'sd1, 16'sd0, 15'd0};
         9:  r = '{OP_ALU, 16'(ALU_DIV), 16'sd0, 15'd0};     // -32768 / -1
         10: r = '{OP_ALU, 16'(ALU_NEG), 16'sd0, 15'd0};     // -(-32768)
         11: r = '{OP_PUSH, 16'sd1, 16'sd0, 15'd0};
         12: r = '{OP_ALU, 16'(ALU_MUL), 16'sd0, 15'd0};     // wraps
         13: r = '{OP_RND, 16'sd1000, 16'sd0, 15'h7FFF};
         14: r = '{OP_DUP, 16'sd0, 16'sd0, 15'd0};
         15: r = '{OP_ALU, 16'(ALU_MOD), 16'sd0, 15'd0};
         16: r = '{OP_JNZ, 16'sd3, 16'sd0, 15'd0};           // zero: falls through
         17: r = '{OP_CALL, 16'sd2, 16'sd0, 15'd0};
         18: r = '{OP_RET, 16'sd0, 16'sd0, 15'd0};
         19: r = '{OP_PUSHI, 16'sd1, 16'sd0, 15'd0};
         20: r = '{OP_IPUSH, 16'sd0, 16'sd0, 15'd0};
         21: r = '{OP_PUSHI, 16'sd2, 16'sd0, 15'd0};
         22: r = '{OP_IPOP, 16'sd0, 16'sd0, 15'd0};
         23: r = '{OP_JMP, -16'sd5, 16'sd0, 15'd0};
         default: r = '{OP_WRITE, 16'sd2, 16'sd0, 15'd0};
      endcase
      return typed;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers. All tasks are entered just after a rising edge.
   // ---------------------------------------------------------------------
   // Sender: bursts of random length separated by random gaps, some gapless.
   task automatic send_instr(req_type r, bit typed = 1'b0, rsp_type want = '0);
      int gap;
      rsp_type got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      got = execute_instr(r);
      pending_results.push_back(typed ? want : got);
      instr_xfers++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   // Config writes only when the block is quiet.
   task automatic wait_idle();
      end_burst();
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_regs(int words, int len);
      csr_write <= 1'b1;
      csr_index <= CSR_MEM_WORDS;
      csr_data  <= 15'(words);
      @(posedge clock);
      csr_index <= CSR_PROG_LEN;
      csr_data  <= 15'(len);
      @(posedge clock);
      csr_write <= 1'b0;
      mem_words = words & 'h7FF;
      prog_len  = len & 'h7FFF;
   endtask

   // Empty the stack and bring the pc back to the start of the program.
   task automatic unwind();
      req_type r;
      r = '0;
      while (stack_ptr > 0) begin
         r.opcode = OP_POP;
         send_instr(r);
      end
      r.opcode = OP_JMP;
      r.operand = 16'(-int'(cur_pc));
      send_instr(r);
   endtask

   task automatic random_stream(int count);
      repeat (count) send_instr(next_instr());
   endtask

   // ---------------------------------------------------------------------
   // Receiver: its own stall pattern, in runs of a randomly picked mode, plus
   // one long hold-off so the block fills and stalls its input.
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int mode, cnt;
      rsp_ready = 1'b0;
      mode = 0;
      cnt = 0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            if (cnt == 0) begin
               mode = $urandom_range(0, 2);
               cnt = 64;
            end
            cnt--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset && rsp_valid && rsp_ready) begin
         result_xfers++;
         if (rsp_payload.write_valid) write_outs++;
         if (pending_results.size() == 0) begin
            $error("unexpected result transfer %p", rsp_payload);
            fails++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.next_pc !== want.next_pc) begin
               $error("next_pc: expected %0d, got %0d", want.next_pc, rsp_payload.next_pc);
               fails++;
            end
            if (rsp_payload.write_valid !== want.write_valid) begin
               $error("write_valid: expected %0b, got %0b",
                      want.write_valid, rsp_payload.write_valid);
               fails++;
            end
            if (rsp_payload.write_value !== want.write_value) begin
               $error("write_value: expected %0d, got %0d",
                      want.write_value, rsp_payload.write_value);
               fails++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fails++;
            end
            if (rsp_payload.stack_level !== want.stack_level) begin
               $error("stack_level: expected %0d, got %0d",
                      want.stack_level, rsp_payload.stack_level);
               fails++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      req_type r;
      rsp_type want;
      bit      typed;
      int      kind;
      string   ending;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      long_hold = 1'b0;
      fails = 0;
      instr_xfers = 0;
      result_xfers = 0;
      write_outs = 0;
      stall_cycles = 0;
      burst_left = 0;
      stack_ptr = 0;
      cur_pc = '0;
      stopped = 1'b0;
      mem_words = MemDepth;
      prog_len = 0;
      foreach (mem_img[i]) begin
         mem_img[i] = '0;
         mem_known[i] = 1'b0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full memory, longest program
      write_regs(MemDepth, 32767);
      for (int i = 0; i < 25; i++) begin
         typed = directed_row(i, r, want);
         send_instr(r, typed, want);
      end

      // random stream; the receiver holds off for a while at its start
      long_hold = 1'b1;
      random_stream(250);
      unwind();
      wait_idle();

      // one usable word: stack and registers collide at address 0
      write_regs(1, 300);
      random_stream(60);
      unwind();
      wait_idle();

      // memory_words past the depth acts as the full depth
      write_regs(2047, 5000);
      random_stream(240);
      wait_idle();

      // The block only stops once per reset, so a single randomly chosen
      // stopping cause ends the run, followed by items it must ignore.
      kind = $urandom_range(0, 5);
      r = next_instr();
      case (kind)
         0: begin r.opcode = OP_HALT; ending = "halt"; end
         1: begin
            r.opcode = 8'($urandom_range(14, 255));
            if (r.opcode == OP_HALT) r.opcode = 8'd200;
            ending = "bad opcode";
         end
         2: begin
            r.opcode = OP_ALU;
            r.operand = $urandom_range(0, 1) ? 16'($urandom_range(16, 32767))
                                             : 16'(-int'($urandom_range(1, 32768)));
            ending = "bad ALU op";
         end
         3: begin r.opcode = OP_PUSH; r.operand = 16'(mem_size()); ending = "bad access"; end
         4: begin r.opcode = OP_RND; r.operand = 16'sd0; ending = "zero rnd bound"; end
         default: begin write_regs(2047, 0); ending = "pc outside program"; end
      endcase
      send_instr(r);
      wait_idle();
      write_regs(MemDepth, 0);
      repeat (6) begin
         r.opcode = 8'($urandom);
         r.operand = 16'($urandom);
         r.input_value = 16'($urandom);
         r.random_value = 15'($urandom);
         send_instr(r);
      end
      end_burst();

      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Ran %0d instruction transfers and %0d result transfers (%0d write outputs)",
               instr_xfers, result_xfers, write_outs);
      $display("over three memory/program settings; stopped by %s.", ending);
      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
